@@ hdl/aere_pkg.sv @@
package aere_pkg;

    localparam int POS_BITS   = 16;
    localparam int RUN_BITS   = POS_BITS + 1;
    localparam int NUM_TOK    = 4;
    localparam int TOK_BITS   = $clog2(NUM_TOK);
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [RUN_BITS-1:0] run_t;

    // token slots of one burst, in emission order
    typedef enum logic [TOK_BITS-1:0] {
        TOK_COL_GAP = 2'd0,
        TOK_ROW_GAP = 2'd1,
        TOK_COL_FIN = 2'd2,
        TOK_ROW_FIN = 2'd3
    } tok_t;

    localparam logic STREAM_ROW = 1'b0;
    localparam logic STREAM_COL = 1'b1;

    // every token that one pair produces
    typedef struct packed {
        logic [NUM_TOK-1:0] mask;
        pos_t               gap_row;
        pos_t               gap_col;
        run_t               run_col_gap;
        run_t               run_row_gap;
        run_t               run_col_fin;
        run_t               run_row_fin;
    } burst_t;

    function automatic run_t sat_add(input run_t a, input pos_t b);
        logic [RUN_BITS:0] s;
        s = {1'b0, a} + {2'b00, b};
        return s[RUN_BITS] ? {RUN_BITS{1'b1}} : s[RUN_BITS-1:0];
    endfunction

endpackage

@@ hdl/aere_front.sv @@
module aere_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aere_pkg::pos_t  row_pos,
    input  aere_pkg::pos_t  col_pos,
    input  logic            last_pair,
    input  logic            q_full,
    output logic            q_push,
    output aere_pkg::burst_t q_data
);
    import aere_pkg::*;

    logic started_reg, started_next;
    pos_t prev_row_reg, prev_row_next;
    pos_t prev_col_reg, prev_col_next;
    run_t row_run_reg, row_run_next;
    run_t col_run_reg, col_run_next;

    logic              accept;
    logic              jump_row, jump_col;
    logic [POS_BITS:0] row_lim, col_lim;
    pos_t              diff_row, diff_col, gap_row, gap_col;
    run_t              row_after_jump, col_after_jump;
    run_t              row_new, col_new;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        row_lim  = {1'b0, prev_row_reg} + (POS_BITS+1)'(1);
        col_lim  = {1'b0, prev_col_reg} + (POS_BITS+1)'(1);
        jump_row = started_reg && ({1'b0, row_pos} > row_lim);
        jump_col = started_reg && ({1'b0, col_pos} > col_lim);
        diff_row = row_pos - prev_row_reg;
        diff_col = col_pos - prev_col_reg;
        gap_row  = diff_row - POS_BITS'(1);
        gap_col  = diff_col - POS_BITS'(1);

        // row gap is added to the row run before the row stream token reads it
        row_after_jump = jump_row ? sat_add(row_run_reg, gap_row) : row_run_reg;
        col_after_jump = jump_row ? '0 : col_run_reg;

        if (!started_reg || jump_col)
            row_new = RUN_BITS'(1);
        else if (jump_row)
            row_new = sat_add(row_run_reg, diff_row);
        else
            row_new = sat_add(row_run_reg, POS_BITS'(1));

        if (!started_reg)
            col_new = RUN_BITS'(1);
        else if (jump_col)
            col_new = sat_add(col_after_jump, diff_col);
        else if (jump_row)
            col_new = RUN_BITS'(1);
        else
            col_new = sat_add(col_run_reg, POS_BITS'(1));
    end

    always_comb
    begin
        q_data.mask        = {last_pair, last_pair, jump_col, jump_row};
        q_data.gap_row     = gap_row;
        q_data.gap_col     = gap_col;
        q_data.run_col_gap = col_run_reg;
        q_data.run_row_gap = row_after_jump;
        q_data.run_col_fin = col_new;
        q_data.run_row_fin = row_new;
        q_push             = accept && (q_data.mask != '0);
    end

    always_comb
    begin
        started_next  = started_reg;
        prev_row_next = prev_row_reg;
        prev_col_next = prev_col_reg;
        row_run_next  = row_run_reg;
        col_run_next  = col_run_reg;
        if (accept)
        begin
            if (last_pair)
            begin
                started_next  = 1'b0;
                prev_row_next = '0;
                prev_col_next = '0;
                row_run_next  = '0;
                col_run_next  = '0;
            end
            else
            begin
                started_next  = 1'b1;
                prev_row_next = row_pos;
                prev_col_next = col_pos;
                row_run_next  = row_new;
                col_run_next  = col_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            prev_row_reg <= '0;
            prev_col_reg <= '0;
            row_run_reg  <= '0;
            col_run_reg  <= '0;
        end
        else
        begin
            started_reg  <= started_next;
            prev_row_reg <= prev_row_next;
            prev_col_reg <= prev_col_next;
            row_run_reg  <= row_run_next;
            col_run_reg  <= col_run_next;
        end
    end

    a_flush_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_pair |=> !started_reg && row_run_reg == '0 && col_run_reg == '0)
        else $error("flush did not clear the alignment state");

    a_no_gap_before_start: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> !jump_row && !jump_col)
        else $error("gap token raised on the first pair");

endmodule

@@ hdl/aere_queue.sv @@
module aere_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aere_pkg::burst_t push_data,
    output logic             full,
    input  logic             pop,
    output aere_pkg::burst_t head,
    output logic             empty
);
    import aere_pkg::*;

    burst_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_BITS'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("burst queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("burst queue read while empty");

endmodule

@@ hdl/aere_back.sv @@
module aere_back (
    input  logic             clk,
    input  logic             rst_n,
    input  aere_pkg::burst_t head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             stream_sel,
    output aere_pkg::run_t   run_count,
    output aere_pkg::pos_t   gap_count,
    output logic             final_token,
    output logic             burst_end
);
    import aere_pkg::*;

    logic [NUM_TOK-1:0] sent_reg, sent_next;
    logic               out_valid_reg, out_valid_next;
    logic               sel_reg;
    run_t               run_reg;
    pos_t               gap_reg;
    logic               fin_reg;
    logic               end_reg;

    logic [NUM_TOK-1:0] pending, rest;
    tok_t               pick;
    logic               load;
    logic               pick_sel, pick_fin;
    run_t               pick_run;
    pos_t               pick_gap;

    always_comb
    begin
        pending = q_empty ? '0 : (head.mask & ~sent_reg);
        pick    = TOK_ROW_FIN;
        for (int i = NUM_TOK - 1; i >= 0; i--)
        begin
            if (pending[i])
                pick = tok_t'(i);
        end
        rest = pending & ~(NUM_TOK'(1) << pick);
    end

    always_comb
    begin
        case (pick)
            TOK_COL_GAP:
            begin
                pick_sel = STREAM_COL;
                pick_run = head.run_col_gap;
                pick_gap = head.gap_row;
                pick_fin = 1'b0;
            end
            TOK_ROW_GAP:
            begin
                pick_sel = STREAM_ROW;
                pick_run = head.run_row_gap;
                pick_gap = head.gap_col;
                pick_fin = 1'b0;
            end
            TOK_COL_FIN:
            begin
                pick_sel = STREAM_COL;
                pick_run = head.run_col_fin;
                pick_gap = '0;
                pick_fin = 1'b1;
            end
            default:
            begin
                pick_sel = STREAM_ROW;
                pick_run = head.run_row_fin;
                pick_gap = '0;
                pick_fin = 1'b1;
            end
        endcase
    end

    // output register refills with the next pending token whenever it is empty or its transfer completes
    always_comb
    begin
        load           = (pending != '0) && (!out_valid_reg || out_ready);
        q_pop          = load && (rest == '0);
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
        sent_next      = sent_reg;
        if (q_pop)
            sent_next = '0;
        else if (load)
            sent_next = sent_reg | (NUM_TOK'(1) << pick);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sel_reg <= pick_sel;
            run_reg <= pick_run;
            gap_reg <= pick_gap;
            fin_reg <= pick_fin;
            end_reg <= (rest == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign stream_sel  = sel_reg;
    assign run_count   = run_reg;
    assign gap_count   = gap_reg;
    assign final_token = fin_reg;
    assign burst_end   = end_reg;

    a_row_final_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fin_reg && sel_reg == STREAM_ROW |-> end_reg)
        else $error("row final token not at the end of its burst");

    a_final_has_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fin_reg |-> gap_reg == '0)
        else $error("final token carries a gap");

endmodule

@@ hdl/alignment_emission_run_encoder_top.sv @@
// path: a pair's burst is written into the queue, then each token is loaded into the output register
// throughput: one pair per cycle unless the queue is full; tokens leave at one per cycle
// while out_ready is high, through the output register, and a four-entry queue holds the
// bursts of up to four pairs; input stalls only while the queue is full, and pairs that make no token never enter it
// reset: asynchronous, clears the alignment state, the queue and the output valid
module alignment_emission_run_encoder_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  aere_pkg::pos_t row_pos,
    input  aere_pkg::pos_t col_pos,
    input  logic           last_pair,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           stream_sel,
    output aere_pkg::run_t run_count,
    output aere_pkg::pos_t gap_count,
    output logic           final_token,
    output logic           burst_end
);
    import aere_pkg::*;

    logic   q_push, q_pop, q_full, q_empty;
    burst_t q_in, q_head;

    aere_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .row_pos   (row_pos),
        .col_pos   (col_pos),
        .last_pair (last_pair),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    aere_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    aere_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stream_sel  (stream_sel),
        .run_count   (run_count),
        .gap_count   (gap_count),
        .final_token (final_token),
        .burst_end   (burst_end)
    );

endmodule
